[rtl/assert_macros.svh]
// assertion macros for the rtl of the hash table engine
// depends on nothing; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/chte_pkg.sv]
// constants, codes and widths of the chained hash table engine
// depends on nothing; used by chained_hash_table_engine_unit
package chte_pkg;

   // table geometry
   localparam int BUCKETS     = 15;
   localparam int CHAIN_DEPTH = 8;
   localparam int ENTRIES     = BUCKETS * CHAIN_DEPTH;

   // field widths fixed by the interface
   localparam int KEY_W    = 16;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = 4;
   localparam int ENTRY_W  = 2 * KEY_W;

   // internal widths derived from the geometry
   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int REM_W  = BKT_W + 1;
   localparam int POS_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
   localparam int FILL_W = $clog2(CHAIN_DEPTH + 1);
   localparam int ADDR_W = $clog2(ENTRIES);

   // bucket hash: sum of id and code, reduced by a reciprocal multiply
   localparam int SUM_W   = KEY_W + 1;
   localparam int PROD_W  = 2 * SUM_W;
   localparam int RECIP_S = SUM_W;
   localparam int RECIP   = (1 << RECIP_S) / BUCKETS;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

[rtl/chte_ram.sv]
// generic single write port, single read port ram with registered read
// depends on nothing; holds the entry store of the hash table engine
module chte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/chained_hash_table_engine_unit.sv]
// top level of the chained hash table engine: sequencer, fill counters, hash unit
// depends on chte_pkg, chte_ram and assert_macros.svh
//
// Hash table of reservation entries with separate chaining. Each request
// (insert, delete, search) hashes (passenger id + reservation code) mod 15 to a
// bucket of up to 8 entries and returns one response with status, matched
// handle, bucket index and the bucket's fill after the operation. One request
// is worked at a time and req_tready stays low until it is finished; a finished
// response waits in an output register, so the next request is taken while it
// is still pending. Hashing goes through one reciprocal multiply: the sum is
// formed on acceptance, then HASH_MUL, HASH_SUB and HASH_FIX form the quotient,
// the remainder and the bucket. A lookup follows, and the response is loaded
// once the output register is free; insert adds nothing more. Search and delete
// scan the bucket one entry per cycle over the single ram read port, newest
// first. A delete then closes the gap, a ram read and then a ram write per entry
// moved, and then updates the fill. No clearing pass after reset: the fill
// counters reset to zero and only entries below a bucket's fill are ever read.
`include "assert_macros.svh"

module chained_hash_table_engine_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // passenger_id, reservation_code, record_handle
   input  logic [1:0]  req_tuser,   // mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found_handle, bucket_index, bucket_fill
   output logic [1:0]  rsp_tuser    // status
);

   // sequencer state codes
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_HASH_MUL = 4'd1;
   localparam logic [3:0] ST_HASH_SUB = 4'd2;
   localparam logic [3:0] ST_HASH_FIX = 4'd3;
   localparam logic [3:0] ST_LOOKUP   = 4'd4;
   localparam logic [3:0] ST_SCAN     = 4'd5;
   localparam logic [3:0] ST_MV_RD    = 4'd6;
   localparam logic [3:0] ST_MV_WR    = 4'd7;
   localparam logic [3:0] ST_DEL_END  = 4'd8;
   localparam logic [3:0] ST_DONE     = 4'd9;

   localparam logic [chte_pkg::SUM_W-1:0] BUCKETS_S =
      chte_pkg::SUM_W'(chte_pkg::BUCKETS);
   localparam logic [chte_pkg::REM_W-1:0] BUCKETS_R =
      chte_pkg::REM_W'(chte_pkg::BUCKETS);
   localparam logic [chte_pkg::PROD_W-1:0] RECIP_P =
      chte_pkg::PROD_W'(chte_pkg::RECIP);
   localparam logic [chte_pkg::FILL_W-1:0] DEPTH_F =
      chte_pkg::FILL_W'(chte_pkg::CHAIN_DEPTH);
   localparam logic [chte_pkg::ADDR_W-1:0] DEPTH_A =
      chte_pkg::ADDR_W'(chte_pkg::CHAIN_DEPTH);

   // control state
   logic [3:0] state_ff, state_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic [chte_pkg::FILL_W-1:0] fill_ff [chte_pkg::BUCKETS];

   // request payload and working registers
   logic [chte_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [chte_pkg::KEY_W-1:0]    code_ff, code_in;
   logic [chte_pkg::KEY_W-1:0]    handle_ff, handle_in;
   logic [chte_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [chte_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [chte_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [chte_pkg::BKT_W-1:0]    bucket_ff, bucket_in;
   logic [chte_pkg::POS_W-1:0]    cmp_pos_ff, cmp_pos_in;
   logic [chte_pkg::FILL_W-1:0]   src_ff, src_in;
   logic [chte_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [chte_pkg::KEY_W-1:0]    found_ff, found_in;

   // response payload registers
   logic [chte_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [chte_pkg::KEY_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [chte_pkg::IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [chte_pkg::CNT_W-1:0]    rsp_fill_ff, rsp_fill_in;

   // ram and fill counter controls
   logic                          ram_we;
   logic [chte_pkg::ADDR_W-1:0]   ram_waddr;
   logic [chte_pkg::ENTRY_W-1:0]  ram_wdata;
   logic [chte_pkg::ADDR_W-1:0]   ram_raddr;
   logic [chte_pkg::ENTRY_W-1:0]  ram_rdata;
   logic                          fill_we;
   logic [chte_pkg::FILL_W-1:0]   fill_wdata;

   // helpers
   logic                          req_fire;
   logic [chte_pkg::FILL_W-1:0]   cur_fill;
   logic [chte_pkg::SUM_W-1:0]    quot;
   logic [chte_pkg::FILL_W-1:0]   src_next;
   logic [chte_pkg::KEY_W-1:0]    rd_code;
   logic [chte_pkg::KEY_W-1:0]    rd_handle;

   // entry address of a position inside a bucket
   function automatic logic [chte_pkg::ADDR_W-1:0] entry_addr(
      input logic [chte_pkg::BKT_W-1:0] bkt,
      input logic [chte_pkg::POS_W-1:0] pos
   );
      entry_addr = chte_pkg::ADDR_W'(chte_pkg::ADDR_W'(bkt) * DEPTH_A)
                 + chte_pkg::ADDR_W'(pos);
   endfunction

   assign req_fire  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign cur_fill  = fill_ff[bucket_ff];
   assign quot      = prod_ff[chte_pkg::RECIP_S +: chte_pkg::SUM_W];
   assign src_next  = src_ff + chte_pkg::FILL_W'(1);
   assign rd_code   = ram_rdata[chte_pkg::KEY_W +: chte_pkg::KEY_W];
   assign rd_handle = ram_rdata[chte_pkg::KEY_W-1:0];

   // entry store: code in the upper half, handle in the lower half
   chte_ram #(
      .WIDTH (chte_pkg::ENTRY_W),
      .DEPTH (chte_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      code_in       = code_ff;
      handle_in     = handle_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      bucket_in     = bucket_ff;
      cmp_pos_in    = cmp_pos_ff;
      src_in        = src_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      ram_we        = 1'b0;
      ram_waddr     = entry_addr(bucket_ff, chte_pkg::POS_W'(cur_fill));
      ram_wdata     = {code_ff, handle_ff};
      ram_raddr     = entry_addr(bucket_ff, cmp_pos_ff);
      fill_we       = 1'b0;
      fill_wdata    = cur_fill;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in   = req_tuser;
               handle_in = req_tdata[47:32];
               code_in   = req_tdata[31:16];
               sum_in    = chte_pkg::SUM_W'(req_tdata[15:0])
                         + chte_pkg::SUM_W'(req_tdata[31:16]);
               status_in = chte_pkg::STATUS_MISS;
               found_in  = '0;
               state_in  = ST_HASH_MUL;
            end
         end

         // quotient estimate through the reciprocal
         ST_HASH_MUL: begin
            prod_in  = chte_pkg::PROD_W'(sum_ff) * RECIP_P;
            state_in = ST_HASH_SUB;
         end

         // remainder, at most one bucket count too large
         ST_HASH_SUB: begin
            rem_in   = chte_pkg::REM_W'(sum_ff - chte_pkg::SUM_W'(quot * BUCKETS_S));
            state_in = ST_HASH_FIX;
         end

         ST_HASH_FIX: begin
            if (rem_ff >= BUCKETS_R) begin
               bucket_in = chte_pkg::BKT_W'(rem_ff - BUCKETS_R);
            end else begin
               bucket_in = chte_pkg::BKT_W'(rem_ff);
            end
            state_in = ST_LOOKUP;
         end

         // dispatch on mode with the bucket's fill at hand
         ST_LOOKUP: begin
            case (mode_ff)
               chte_pkg::MODE_INSERT: begin
                  if (cur_fill >= DEPTH_F) begin
                     status_in = chte_pkg::STATUS_FULL;
                  end else begin
                     // newest entry goes at the top of the occupied range
                     ram_we     = 1'b1;
                     fill_we    = 1'b1;
                     fill_wdata = cur_fill + chte_pkg::FILL_W'(1);
                     status_in  = chte_pkg::STATUS_OK;
                  end
                  state_in = ST_DONE;
               end
               chte_pkg::MODE_DELETE, chte_pkg::MODE_SEARCH: begin
                  if (cur_fill == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     cmp_pos_in = chte_pkg::POS_W'(cur_fill - chte_pkg::FILL_W'(1));
                     ram_raddr  = entry_addr(bucket_ff, cmp_pos_in);
                     state_in   = ST_SCAN;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         // scan from newest to oldest, one entry a cycle
         ST_SCAN: begin
            if (cmp_pos_ff != '0) begin
               ram_raddr = entry_addr(bucket_ff, cmp_pos_ff - chte_pkg::POS_W'(1));
            end
            if (rd_code == code_ff) begin
               found_in  = rd_handle;
               status_in = chte_pkg::STATUS_OK;
               if (mode_ff == chte_pkg::MODE_DELETE) begin
                  src_in = chte_pkg::FILL_W'(cmp_pos_ff) + chte_pkg::FILL_W'(1);
                  if ((chte_pkg::FILL_W'(cmp_pos_ff) + chte_pkg::FILL_W'(1)) < cur_fill) begin
                     state_in = ST_MV_RD;
                  end else begin
                     state_in = ST_DEL_END;
                  end
               end else begin
                  state_in = ST_DONE;
               end
            end else if (cmp_pos_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cmp_pos_in = cmp_pos_ff - chte_pkg::POS_W'(1);
            end
         end

         // close the gap: move each newer entry down by one
         ST_MV_RD: begin
            ram_raddr = entry_addr(bucket_ff, chte_pkg::POS_W'(src_ff));
            state_in  = ST_MV_WR;
         end

         ST_MV_WR: begin
            ram_we    = 1'b1;
            ram_waddr = entry_addr(bucket_ff,
                                   chte_pkg::POS_W'(src_ff - chte_pkg::FILL_W'(1)));
            ram_wdata = ram_rdata;
            src_in    = src_next;
            if (src_next < cur_fill) begin
               state_in = ST_MV_RD;
            end else begin
               state_in = ST_DEL_END;
            end
         end

         ST_DEL_END: begin
            fill_we    = 1'b1;
            fill_wdata = cur_fill - chte_pkg::FILL_W'(1);
            state_in   = ST_DONE;
         end

         // load the response once the output register is free
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_index_in  = chte_pkg::IDX_W'(bucket_ff);
               rsp_fill_in   = chte_pkg::CNT_W'(cur_fill);
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // per-bucket fill counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < chte_pkg::BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
      end else if (fill_we) begin
         fill_ff[bucket_ff] <= fill_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      code_ff       <= code_in;
      handle_ff     <= handle_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      bucket_ff     <= bucket_in;
      cmp_pos_ff    <= cmp_pos_in;
      src_ff        <= src_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   // response outputs
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_fill_ff, rsp_index_ff, rsp_found_ff};

   // checks on the sequencer
   `CHK_ALWAYS(a_ram_write_state, clock, reset,
      !ram_we || state_ff == ST_LOOKUP || state_ff == ST_MV_WR,
      "entry ram written outside insert or gap move")
   `CHK_ALWAYS(a_bucket_range, clock, reset,
      state_ff != ST_LOOKUP || bucket_ff < chte_pkg::BKT_W'(chte_pkg::BUCKETS),
      "hashed bucket out of range")
   `CHK_ALWAYS(a_fill_bound, clock, reset,
      state_ff != ST_DONE || cur_fill <= DEPTH_F,
      "bucket fill above chain depth")
   `CHK_NEXT(a_done_holds, clock, reset,
      state_ff == ST_DONE && rsp_tvalid_ff && !rsp_tready,
      state_ff == ST_DONE,
      "response overwritten while previous one pending")

endmodule

[bench/tb_chained_hash_table_engine_unit.sv]
`timescale 1ns / 1ps
// self-checking bench for chained_hash_table_engine_unit: a directed table, then random traffic
// depends on chte_pkg and the unit's rtl; expected responses come from a local bucket model

module tb_chained_hash_table_engine_unit;

   // mode 3 has no package name: the unit answers it without touching the table
   localparam logic [chte_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_OPS    = 1852;
   localparam int PHASES        = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HISTORY_MAX   = 128;

   typedef struct packed {
      logic [chte_pkg::MODE_W-1:0] mode;
      logic [chte_pkg::KEY_W-1:0]  passenger_id;
      logic [chte_pkg::KEY_W-1:0]  reservation_code;
      logic [chte_pkg::KEY_W-1:0]  record_handle;
   } table_op_type;

   typedef struct packed {
      logic [chte_pkg::STATUS_W-1:0] status;
      logic [chte_pkg::KEY_W-1:0]    found_handle;
      logic [chte_pkg::IDX_W-1:0]    bucket_index;
      logic [chte_pkg::CNT_W-1:0]    bucket_fill;
   } table_result_type;

   typedef struct {
      table_op_type     op;
      bit               typed;
      table_result_type result;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // passenger_id, reservation_code, record_handle
   logic [1:0]  req_tuser  = '0;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // found_handle, bucket_index, bucket_fill
   logic [1:0]  rsp_tuser;         // status

   // bucket model: position 0 is the newest entry of a bucket
   logic [chte_pkg::KEY_W-1:0] model_code   [chte_pkg::BUCKETS][chte_pkg::CHAIN_DEPTH];
   logic [chte_pkg::KEY_W-1:0] model_handle [chte_pkg::BUCKETS][chte_pkg::CHAIN_DEPTH];
   int unsigned                model_fill   [chte_pkg::BUCKETS] = '{default: 0};

   table_result_type pending_results [$];
   int               src_idle_pct   = 0;
   int               sink_stall_pct = 0;
   int               mismatch_count = 0;
   int unsigned      cycle_count    = 0;
   int unsigned      status_seen [4] = '{default: 0};

   always #2 clock = ~clock;

   chained_hash_table_engine_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // apply one operation to the bucket model and return the response it causes
   function automatic table_result_type apply_table_op(input table_op_type op);
      table_result_type r;
      int unsigned      b;
      int               pos;
      int               i;
      b   = (int'(op.passenger_id) + int'(op.reservation_code)) % chte_pkg::BUCKETS;
      pos = -1;
      r.status       = chte_pkg::STATUS_MISS;
      r.found_handle = '0;
      r.bucket_index = chte_pkg::IDX_W'(b);
      // newest matching code, searched from the head
      for (i = 0; i < int'(model_fill[b]); i++) begin
         if (pos < 0 && model_code[b][i] == op.reservation_code) pos = i;
      end
      case (op.mode)
         chte_pkg::MODE_INSERT: begin
            if (model_fill[b] >= chte_pkg::CHAIN_DEPTH) begin
               r.status = chte_pkg::STATUS_FULL;
            end else begin
               for (i = int'(model_fill[b]); i > 0; i--) begin
                  model_code[b][i]   = model_code[b][i-1];
                  model_handle[b][i] = model_handle[b][i-1];
               end
               model_code[b][0]   = op.reservation_code;
               model_handle[b][0] = op.record_handle;
               model_fill[b]++;
               r.status = chte_pkg::STATUS_OK;
            end
         end
         chte_pkg::MODE_DELETE: begin
            if (pos >= 0) begin
               r.found_handle = model_handle[b][pos];
               // close the gap behind the removed entry
               for (i = pos; i + 1 < int'(model_fill[b]); i++) begin
                  model_code[b][i]   = model_code[b][i+1];
                  model_handle[b][i] = model_handle[b][i+1];
               end
               model_fill[b]--;
               r.status = chte_pkg::STATUS_OK;
            end
         end
         chte_pkg::MODE_SEARCH: begin
            if (pos >= 0) begin
               r.found_handle = model_handle[b][pos];
               r.status       = chte_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
      r.bucket_fill = chte_pkg::CNT_W'(model_fill[b]);
      return r;
   endfunction

   // present one request transaction after a random gap; expectation is queued on acceptance
   task automatic issue_op(
      input table_op_type     op,
      input bit               typed,
      input table_result_type typed_result
   );
      table_result_type predicted;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {op.record_handle, op.reservation_code, op.passenger_id};
      req_tuser  <= op.mode;
      do @(posedge clock); while (!req_tready);
      predicted = apply_table_op(op);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // hold the request side until every queued response has arrived
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic directed_row_type drow(
      input logic [chte_pkg::MODE_W-1:0]   mode,
      input logic [chte_pkg::KEY_W-1:0]    id,
      input logic [chte_pkg::KEY_W-1:0]    code,
      input logic [chte_pkg::KEY_W-1:0]    handle,
      input bit                            typed,
      input logic [chte_pkg::STATUS_W-1:0] status,
      input logic [chte_pkg::KEY_W-1:0]    found,
      input logic [chte_pkg::IDX_W-1:0]    idx,
      input logic [chte_pkg::CNT_W-1:0]    fill);
      directed_row_type row;
      row.op     = '{mode, id, code, handle};
      row.typed  = typed;
      row.result = '{status, found, idx, fill};
      return row;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // response side: random stalls, each transaction checked against the oldest expectation
   always @(posedge clock) begin
      table_result_type want;
      table_result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[15:0], rsp_tdata[19:16], rsp_tdata[23:20]};
            if (pending_results.size() == 0) begin
               $display("%0t ns: response with nothing expected, actual status %0d handle 0x%0h",
                        $time, got.status, got.found_handle);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("found_handle", 32'(want.found_handle), 32'(got.found_handle));
               check_field("bucket_index", 32'(want.bucket_index), 32'(got.bucket_index));
               check_field("bucket_fill", 32'(want.bucket_fill), 32'(got.bucket_fill));
               status_seen[got.status]++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("chained_hash_table_engine_unit regression: fail");
         $finish;
      end
   end

   initial begin
      directed_row_type directed_rows [$];
      logic [31:0]      placed [$];   // {passenger_id, reservation_code} of inserted entries
      table_op_type     op;
      int               src_pct  [PHASES] = '{0, 61, 0, 6};
      int               sink_pct [PHASES] = '{0, 0, 61, 6};
      int               pick;
      int               slot;
      int               p;
      int               n;

      // empty table, then the code and id extremes
      directed_rows.push_back(drow(chte_pkg::MODE_SEARCH, 16'h0000, 16'h0000, 16'h0000,
                                   1'b1, chte_pkg::STATUS_MISS, 16'h0000, 4'd0, 4'd0));
      directed_rows.push_back(drow(chte_pkg::MODE_DELETE, 16'h0000, 16'h0000, 16'h0000,
                                   1'b1, chte_pkg::STATUS_MISS, 16'h0000, 4'd0, 4'd0));
      directed_rows.push_back(drow(MODE_UNUSED, 16'h0000, 16'h0000, 16'h0000,
                                   1'b1, chte_pkg::STATUS_MISS, 16'h0000, 4'd0, 4'd0));
      directed_rows.push_back(drow(chte_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   1'b1, chte_pkg::STATUS_OK, 16'h0000, 4'd0, 4'd1));
      directed_rows.push_back(drow(chte_pkg::MODE_SEARCH, 16'h0000, 16'hFFFF, 16'h0000,
                                   1'b1, chte_pkg::STATUS_OK, 16'hFFFF, 4'd0, 4'd1));
      // fill bucket 0 to its depth, then one insert too many
      for (n = 1; n < chte_pkg::CHAIN_DEPTH; n++) begin
         directed_rows.push_back(drow(chte_pkg::MODE_INSERT, 16'h0000,
                                      chte_pkg::KEY_W'(15 * n), chte_pkg::KEY_W'(n),
                                      1'b0, '0, '0, '0, '0));
      end
      directed_rows.push_back(drow(chte_pkg::MODE_INSERT, 16'h0000, 16'd150, 16'hABCD,
                                   1'b1, chte_pkg::STATUS_FULL, 16'h0000, 4'd0, 4'd8));
      // delete from the middle of a full chain
      directed_rows.push_back(drow(chte_pkg::MODE_SEARCH, 16'h0000, 16'd45, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(chte_pkg::MODE_DELETE, 16'h0000, 16'd45, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(chte_pkg::MODE_SEARCH, 16'h0000, 16'd45, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(MODE_UNUSED, 16'hFFFF, 16'h0000, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      // duplicate codes in the top bucket, reached through different ids
      directed_rows.push_back(drow(chte_pkg::MODE_INSERT, 16'd14, 16'h0000, 16'h1111,
                                   1'b1, chte_pkg::STATUS_OK, 16'h0000, 4'd14, 4'd1));
      directed_rows.push_back(drow(chte_pkg::MODE_INSERT, 16'd29, 16'h0000, 16'h2222,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(chte_pkg::MODE_SEARCH, 16'd14, 16'h0000, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(chte_pkg::MODE_DELETE, 16'd44, 16'h0000, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(chte_pkg::MODE_SEARCH, 16'd14, 16'h0000, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(chte_pkg::MODE_SEARCH, 16'hFFFF, 16'h000E, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      // remove the oldest entry of bucket 0, then refill it
      directed_rows.push_back(drow(chte_pkg::MODE_DELETE, 16'h0000, 16'hFFFF, 16'h0000,
                                   1'b0, '0, '0, '0, '0));
      directed_rows.push_back(drow(chte_pkg::MODE_INSERT, 16'h8000, 16'h7FFF, 16'h5A5A,
                                   1'b0, '0, '0, '0, '0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         issue_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].result);
      end
      drain_responses();

      // random traffic, mostly reusing keys already placed so lookups hit
      for (p = 0; p < PHASES; p++) begin
         src_idle_pct   = src_pct[p];
         sink_stall_pct <= sink_pct[p];
         for (n = 0; n < RANDOM_OPS / PHASES; n++) begin
            pick                = $urandom_range(99);
            op.passenger_id     = chte_pkg::KEY_W'($urandom);
            op.reservation_code = chte_pkg::KEY_W'($urandom);
            op.record_handle    = chte_pkg::KEY_W'($urandom);
            if (pick < 33) begin
               op.mode = chte_pkg::MODE_INSERT;
               if (placed.size() != 0 && $urandom_range(1) == 1) begin
                  op.reservation_code = placed[$urandom_range(placed.size() - 1)][15:0];
               end
               placed.push_back({op.passenger_id, op.reservation_code});
               if (placed.size() > HISTORY_MAX) void'(placed.pop_front());
            end else if (pick < 88 && placed.size() != 0) begin
               op.mode = (pick < 58) ? chte_pkg::MODE_SEARCH : chte_pkg::MODE_DELETE;
               slot = $urandom_range(placed.size() - 1);
               {op.passenger_id, op.reservation_code} = placed[slot];
               // another id that lands in the same bucket
               if (op.passenger_id < 16'hFFF0 && $urandom_range(3) == 0) begin
                  op.passenger_id = op.passenger_id + 16'd15;
               end
               if (op.mode == chte_pkg::MODE_DELETE) placed.delete(slot);
            end else if (pick < 95) begin
               op.mode = ($urandom_range(1) == 1) ? chte_pkg::MODE_SEARCH
                                                  : chte_pkg::MODE_DELETE;
            end else begin
               op.mode = MODE_UNUSED;
            end
            issue_op(op, 1'b0, '0);
         end
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered insert, delete, search and the unused mode over four handshake phases");
      $display("responses: %0d found or done, %0d not found, %0d bucket full, %0d mismatches",
               status_seen[chte_pkg::STATUS_OK], status_seen[chte_pkg::STATUS_MISS],
               status_seen[chte_pkg::STATUS_FULL], mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("chained_hash_table_engine_unit regression: pass");
      end else begin
         $display("chained_hash_table_engine_unit regression: fail");
      end
      $finish;
   end

endmodule
